// ===== design/tpig_pkg.sv =====
// Shared constants, codes and types of the terrain patch index generator.
package tpig_pkg;

  localparam int unsigned LodLimit         = 8;
  localparam int unsigned IndexBitsDefault = 16;
  localparam int unsigned RowBits          = 8;
  localparam int unsigned LodBits          = 4;
  localparam int unsigned LevelBits        = 3;
  localparam int unsigned MaskBits         = 4;
  localparam int unsigned CountBits        = 7;
  localparam int unsigned CoordBits        = 9;
  localparam int unsigned OctantBits       = 3;
  localparam int unsigned CfgIndexBits     = 1;
  localparam int unsigned CfgDataBits      = 8;
  localparam int unsigned QueueDepth       = 2;

  localparam logic [RowBits-1:0]    RowVerticesReset = 8'd129;
  localparam logic [LodBits-1:0]    LodCountReset    = 4'd8;
  localparam logic [OctantBits-1:0] OctantLast       = 3'd7;

  typedef enum logic {
    CmdStart = 1'b0,
    CmdStep  = 1'b1
  } command_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgRowVertices = 1'b0,
    CfgLodCount    = 1'b1
  } cfg_index_e;

  // One triangle in patch-local sweep coordinates plus its transform.
  typedef struct packed {
    logic [2:0][CoordBits-1:0] px;
    logic [2:0][CoordBits-1:0] py;
    logic [LevelBits-1:0]      shift;
    logic                      neg_x;
    logic                      neg_y;
    logic                      flip;
    logic                      swap;
    logic                      coarse;
    logic                      fin;
  } tri_desc_t;

endpackage

// ===== design/tpig_if.sv =====
// Valid/ready channel interfaces: input items, result items, configuration writes.
interface tpig_in_if import tpig_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [LevelBits-1:0] detail_level;
  logic [MaskBits-1:0]  zone_mask;

  modport source (output valid, command, detail_level, zone_mask, input ready);
  modport sink   (input valid, command, detail_level, zone_mask, output ready);
endinterface

interface tpig_out_if import tpig_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDefault
) ();
  logic                 valid;
  logic                 ready;
  logic [IndexBits-1:0] corner_a;
  logic [IndexBits-1:0] corner_b;
  logic [IndexBits-1:0] corner_c;
  logic                 final_triangle;

  modport source (output valid, corner_a, corner_b, corner_c, final_triangle,
                  input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, final_triangle,
                  output ready);
endinterface

interface tpig_cfg_if import tpig_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIndexBits-1:0] index;
  logic [CfgDataBits-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/terrain_patch_index_generator_top.sv =====
// Top level of the terrain patch index generator: config registers, front, queue, back.
// A step's triangle is registered in the queue, the coordinate stage and the output stage.
// Throughput: one item per cycle while the output is not stalled.
// A start command gives no result; idle steps are dropped.
// Reset (async, active low) clears all control state and the queue at once;
// row_vertices resets to 129 and lod_count to 8, with no clearing pass.
module terrain_patch_index_generator_top import tpig_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tpig_cfg_if.sink   cfg_i,
  tpig_in_if.sink    in_i,
  tpig_out_if.source out_o
);

  logic [RowBits-1:0] row_vertices_q;
  logic [LodBits-1:0] lod_count_q;

  logic      push, full, pop, empty;
  tri_desc_t desc_in, desc_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vertices_q <= RowVerticesReset;
      lod_count_q    <= LodCountReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CfgRowVertices: row_vertices_q <= cfg_i.data[RowBits-1:0];
        CfgLodCount:    lod_count_q    <= cfg_i.data[LodBits-1:0];
        default:        ;
      endcase
    end
  end

  tpig_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .lod_count_i (lod_count_q),
    .full_i      (full),
    .push_o      (push),
    .desc_o      (desc_in)
  );

  tpig_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (desc_out)
  );

  tpig_back #(
    .IndexBits (IndexBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .desc_i         (desc_out),
    .row_vertices_i (row_vertices_q),
    .pop_o          (pop),
    .out_o          (out_o)
  );

endmodule

// ===== design/tpig_front.sv =====
// Front end: takes commands, walks the octant sweep and queues triangle descriptors.
module tpig_front import tpig_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  tpig_in_if.sink            in_i,
  input  logic [LodBits-1:0] lod_count_i,
  input  logic               full_i,
  output logic               push_o,
  output tri_desc_t          desc_o
);

  logic [LevelBits-1:0]  level_hold_q, level_hold_d;
  logic [MaskBits-1:0]   mask_hold_q, mask_hold_d;
  logic [OctantBits-1:0] octant_q, octant_d;
  logic [CountBits-1:0]  sweep_row_q, sweep_row_d;
  logic [CountBits-1:0]  sweep_col_q, sweep_col_d;
  logic                  second_half_q, second_half_d;
  logic                  busy_q, busy_d;

  logic                  acc;
  logic [LodBits-1:0]    lc;
  logic [LevelBits-1:0]  lv;
  logic [LevelBits-1:0]  rlog;
  logic [CountBits-1:0]  half_m1;
  logic [1:0]            zone;
  logic                  stitched;
  logic                  last_row;
  logic                  row_end;
  logic                  odd;
  logic [CoordBits-1:0]  cx, cy, co;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    lc = lod_count_i;
    if (lc == '0) begin
      lc = LodBits'(1);
    end else if (lc > LodBits'(LodLimit)) begin
      lc = LodBits'(LodLimit);
    end
    lv = level_hold_q;
    if (LodBits'(level_hold_q) > lc - LodBits'(1)) begin
      lv = LevelBits'(lc - LodBits'(1));
    end
    rlog    = LevelBits'(lc - LodBits'(1) - LodBits'(lv));
    half_m1 = (CountBits'(1) << (rlog - LevelBits'(1))) - CountBits'(1);

    zone     = octant_q[2:1];
    stitched = mask_hold_q[zone];
    last_row = sweep_row_q >= half_m1;
    row_end  = sweep_col_q >= sweep_row_q;
    odd      = sweep_col_q[0] ^ sweep_row_q[0];
    cx       = CoordBits'(sweep_col_q);
    cy       = CoordBits'(sweep_row_q);
    co       = CoordBits'(odd);

    level_hold_d  = level_hold_q;
    mask_hold_d   = mask_hold_q;
    octant_d      = octant_q;
    sweep_row_d   = sweep_row_q;
    sweep_col_d   = sweep_col_q;
    second_half_d = second_half_q;
    busy_d        = busy_q;
    push_o        = 1'b0;

    desc_o        = '0;
    desc_o.shift  = lv;
    desc_o.neg_x  = octant_q[0];
    desc_o.neg_y  = (zone == 2'd0) || (zone == 2'd3);
    desc_o.flip   = zone[0];
    desc_o.swap   = octant_q[0] ^ desc_o.neg_y ^ !zone[0];

    if (rlog == '0) begin
      desc_o.coarse = 1'b1;
      desc_o.swap   = 1'b0;
      desc_o.flip   = 1'b0;
      if (sweep_col_q == '0) begin
        desc_o.px = {CoordBits'(1), CoordBits'(1), CoordBits'(0)};
        desc_o.py = {CoordBits'(0), CoordBits'(1), CoordBits'(0)};
      end else begin
        desc_o.px = {CoordBits'(1), CoordBits'(0), CoordBits'(0)};
        desc_o.py = {CoordBits'(1), CoordBits'(1), CoordBits'(0)};
        desc_o.fin = 1'b1;
      end
    end else if (!second_half_q) begin
      desc_o.px[0] = cx;
      desc_o.py[0] = cy;
      desc_o.px[1] = cx + CoordBits'(1);
      desc_o.py[1] = cy + CoordBits'(1) - co;
      desc_o.px[2] = (stitched && last_row) ? cx - CoordBits'(1) + co : cx;
      desc_o.py[2] = cy + CoordBits'(1);
      desc_o.fin   = row_end && last_row && (octant_q == OctantLast);
    end else begin
      desc_o.px[0] = cx;
      desc_o.py[0] = cy + co;
      desc_o.px[1] = cx + CoordBits'(1);
      desc_o.py[1] = cy;
      desc_o.px[2] = cx + CoordBits'(1);
      desc_o.py[2] = cy + CoordBits'(1);
    end

    if (acc) begin
      if (in_i.command == CmdStart) begin
        level_hold_d  = in_i.detail_level;
        mask_hold_d   = in_i.zone_mask;
        octant_d      = '0;
        sweep_row_d   = '0;
        sweep_col_d   = '0;
        second_half_d = 1'b0;
        busy_d        = 1'b1;
      end else if (busy_q) begin
        push_o = 1'b1;
        if (rlog == '0) begin
          if (sweep_col_q == '0) begin
            sweep_col_d = CountBits'(1);
          end else begin
            busy_d = 1'b0;
          end
        end else begin
          priority if (second_half_q) begin
            second_half_d = 1'b0;
            sweep_col_d   = sweep_col_q + CountBits'(1);
          end else if (row_end) begin
            sweep_col_d = '0;
            if (last_row) begin
              sweep_row_d = '0;
              if (octant_q == OctantLast) begin
                busy_d   = 1'b0;
                octant_d = '0;
              end else begin
                octant_d = octant_q + OctantBits'(1);
              end
            end else begin
              sweep_row_d = sweep_row_q + CountBits'(1);
            end
          end else if (stitched && last_row && odd) begin
            sweep_col_d = sweep_col_q + CountBits'(1);
          end else begin
            second_half_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_hold_q  <= '0;
      mask_hold_q   <= '0;
      octant_q      <= '0;
      sweep_row_q   <= '0;
      sweep_col_q   <= '0;
      second_half_q <= 1'b0;
      busy_q        <= 1'b0;
    end else begin
      level_hold_q  <= level_hold_d;
      mask_hold_q   <= mask_hold_d;
      octant_q      <= octant_d;
      sweep_row_q   <= sweep_row_d;
      sweep_col_q   <= sweep_col_d;
      second_half_q <= second_half_d;
      busy_q        <= busy_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && desc_o.fin |=> !busy_q)
    else $error("front still busy after final triangle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_i.command == CmdStart) |=>
      busy_q && (octant_q == '0) && (sweep_row_q == '0) && !second_half_q)
    else $error("start did not rewind the sweep");

endmodule

// ===== design/tpig_fifo.sv =====
// Short descriptor queue between front end and back end.
module tpig_fifo import tpig_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tri_desc_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output tri_desc_t data_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  tri_desc_t            mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   count_q;

  assign full_o  = count_q == CntBits'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overflow or underflow");

endmodule

// ===== design/tpig_back.sv =====
// Back end: maps descriptors to grid coordinates, then to vertex indices.
module tpig_back import tpig_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  tri_desc_t          desc_i,
  input  logic [RowBits-1:0] row_vertices_i,
  output logic               pop_o,
  tpig_out_if.source         out_o
);

  logic                      a_v_q;
  logic [2:0][IndexBits-1:0] gx_q, gy_q, gx_d, gy_d;
  logic                      a_swap_q, a_fin_q;

  logic                      out_v_q;
  logic [IndexBits-1:0]      ca_q, cb_q, cc_q;
  logic                      fin_q;

  logic                      out_adv, a_load;
  logic [31:0]               rv32, c32;
  logic [31:0]               mx, my, ax, ay;
  logic [2:0][IndexBits-1:0] idx;
  logic [IndexBits+RowBits-1:0] prod;

  assign out_adv = !out_v_q || out_o.ready;
  assign a_load  = !a_v_q || out_adv;
  assign pop_o   = !empty_i && a_load;

  always_comb begin
    rv32 = 32'(row_vertices_i);
    c32  = rv32 >> 1;
    gx_d = '0;
    gy_d = '0;
    for (int k = 0; k < 3; k++) begin
      mx = 32'($signed(desc_i.px[k])) << desc_i.shift;
      my = 32'($signed(desc_i.py[k])) << desc_i.shift;
      ax = (desc_i.neg_x ? -mx : mx) + c32;
      ay = (desc_i.neg_y ? -my : my) + c32;
      if (desc_i.coarse) begin
        ax = desc_i.px[k][0] ? rv32 - 32'd1 : '0;
        ay = desc_i.py[k][0] ? rv32 - 32'd1 : '0;
      end
      gx_d[k] = desc_i.flip ? ay[IndexBits-1:0] : ax[IndexBits-1:0];
      gy_d[k] = desc_i.flip ? ax[IndexBits-1:0] : ay[IndexBits-1:0];
    end
  end

  always_comb begin
    idx  = '0;
    prod = '0;
    for (int k = 0; k < 3; k++) begin
      prod   = gy_q[k] * row_vertices_i;
      idx[k] = gx_q[k] + prod[IndexBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load && pop_o) begin
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      a_swap_q <= desc_i.swap;
      a_fin_q  <= desc_i.fin;
    end
    if (out_adv && a_v_q) begin
      ca_q  <= a_swap_q ? idx[1] : idx[0];
      cb_q  <= a_swap_q ? idx[0] : idx[1];
      cc_q  <= idx[2];
      fin_q <= a_fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_load) begin
        a_v_q <= pop_o;
      end
      if (out_adv) begin
        out_v_q <= a_v_q;
      end
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.corner_a       = ca_q;
  assign out_o.corner_b       = cb_q;
  assign out_o.corner_c       = cc_q;
  assign out_o.final_triangle = fin_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v_q && !out_adv |=> a_v_q && $stable(gx_q) && $stable(gy_q))
    else $error("coordinate stage lost an item under stall");

endmodule
